@@ hw/rtl/dhcplt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dhcplt_pkg;

  localparam int unsigned POOL_DEPTH = 8;
  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  localparam logic [31:0] TENTATIVE_MS = 32'd15000;
  localparam logic [31:0] MS_PER_SEC   = 32'd1000;

  localparam logic [31:0] SERVER_IP_RST  = 32'd3232236545;
  localparam logic [7:0]  POOL_FIRST_RST = 8'd2;
  localparam logic [7:0]  POOL_LAST_RST  = 8'd9;
  localparam logic [31:0] LEASE_SECS_RST = 32'd3600;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_IP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECS = 3'd3;

  localparam logic [2:0] REQ_DISCOVER = 3'd0;
  localparam logic [2:0] REQ_REQUEST  = 3'd1;
  localparam logic [2:0] REQ_RELEASE  = 3'd2;
  localparam logic [2:0] REQ_DECLINE  = 3'd3;
  localparam logic [2:0] REQ_INFORM   = 3'd4;
  localparam logic [2:0] REQ_LOOKUP   = 3'd6;

  localparam logic [2:0] RPL_NONE    = 3'd0;
  localparam logic [2:0] RPL_OFFER   = 3'd1;
  localparam logic [2:0] RPL_ACK     = 3'd2;
  localparam logic [2:0] RPL_NAK     = 3'd3;
  localparam logic [2:0] RPL_FOUND   = 3'd4;
  localparam logic [2:0] RPL_MISSING = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [47:0] client_mac;
    logic [31:0] now_ms;
    logic        server_id_present;
    logic [31:0] server_id;
    logic        requested_present;
    logic [31:0] requested_ip;
    logic [31:0] client_addr;
    logic        reserved_hit;
    logic [7:0]  reserved_octet;
  } req_t;

  typedef struct packed {
    logic [2:0]  reply;
    logic [31:0] your_ip;
    logic        from_reservation;
    logic [2:0]  lease_slot;
    logic        pool_full;
  } rsp_t;

  typedef struct packed {
    logic [31:0] server_ip;
    logic [7:0]  pool_first;
    logic [7:0]  pool_last;
    logic [31:0] lease_secs;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic             clr_used;
    logic [IDX_W-1:0] idx;
    logic [47:0]      mac;
    logic [31:0]      expiry;
  } slot_wr_t;

  typedef struct packed {
    logic        used;
    logic [47:0] mac;
    logic [31:0] expiry;
  } slot_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/dhcplt_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhcplt_cfg_regs (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [dhcplt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [31:0]                      cfg_wdata_i,
  output dhcplt_pkg::cfg_t                cfg_o,
  output logic [dhcplt_pkg::CNT_W-1:0]    pool_size_o
);
  import dhcplt_pkg::*;

  cfg_t       cfg_q;
  logic [8:0] span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.server_ip  <= SERVER_IP_RST;
      cfg_q.pool_first <= POOL_FIRST_RST;
      cfg_q.pool_last  <= POOL_LAST_RST;
      cfg_q.lease_secs <= LEASE_SECS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SERVER_IP:  cfg_q.server_ip  <= cfg_wdata_i;
        CFG_POOL_FIRST: cfg_q.pool_first <= cfg_wdata_i[7:0];
        CFG_POOL_LAST:  cfg_q.pool_last  <= cfg_wdata_i[7:0];
        CFG_LEASE_SECS: cfg_q.lease_secs <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Usable slots: the octet span of the pool, clamped to the table depth.
  always_comb begin
    span = {1'b0, cfg_q.pool_last} - {1'b0, cfg_q.pool_first} + 9'd1;
    if (cfg_q.pool_last < cfg_q.pool_first) begin
      pool_size_o = '0;
    end else if (span > 9'(POOL_DEPTH)) begin
      pool_size_o = CNT_W'(POOL_DEPTH);
    end else begin
      pool_size_o = CNT_W'(span);
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/dhcplt_lease_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhcplt_lease_store (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           rd_en_i,
  input  wire [dhcplt_pkg::IDX_W-1:0]   rd_idx_i,
  input  dhcplt_pkg::slot_wr_t          wr_i,
  output dhcplt_pkg::slot_rd_t          rd_o
);
  import dhcplt_pkg::*;

  logic [47:0]           mac_mem [POOL_DEPTH];
  logic [31:0]           exp_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] used_q;
  logic                  rd_used_q;
  logic [47:0]           rd_mac_q;
  logic [31:0]           rd_exp_q;

  // Valid bits clear at reset; the payload memory needs no clearing since a
  // slot whose valid bit is low is never compared on its contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (wr_i.wr_en) begin
        used_q[wr_i.idx] <= 1'b1;
      end else if (wr_i.clr_used) begin
        used_q[wr_i.idx] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_used_q <= used_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mac_mem[wr_i.idx] <= wr_i.mac;
      exp_mem[wr_i.idx] <= wr_i.expiry;
    end
    if (rd_en_i) begin
      rd_mac_q <= mac_mem[rd_idx_i];
      rd_exp_q <= exp_mem[rd_idx_i];
    end
  end

  assign rd_o.used   = rd_used_q;
  assign rd_o.mac    = rd_mac_q;
  assign rd_o.expiry = rd_exp_q;

endmodule

`default_nettype wire

@@ hw/rtl/dhcplt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhcplt_ctrl (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  dhcplt_pkg::req_t              req_i,
  input  dhcplt_pkg::cfg_t              cfg_i,
  input  wire [dhcplt_pkg::CNT_W-1:0]   pool_size_i,
  output logic                          rd_en_o,
  output logic [dhcplt_pkg::IDX_W-1:0]  rd_idx_o,
  input  dhcplt_pkg::slot_rd_t          rd_i,
  output dhcplt_pkg::slot_wr_t          wr_o,
  output logic                          done_o,
  output dhcplt_pkg::rsp_t              rsp_o
);
  import dhcplt_pkg::*;

  ctrl_state_e      state_q, state_d;
  req_t             req_q, req_d;
  logic [31:0]      lease_ms_q, lease_ms_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             live_fnd_q, live_fnd_d;
  logic [IDX_W-1:0] live_idx_q, live_idx_d;
  logic             free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             expired;
  logic             foreign;
  logic             dyn;
  logic [IDX_W-1:0] dyn_idx;
  logic [31:0]      offer;
  logic [31:0]      want;
  logic             ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      live_fnd_q <= 1'b0;
      free_fnd_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      live_fnd_q <= live_fnd_d;
      free_fnd_q <= free_fnd_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    lease_ms_q <= lease_ms_d;
    cmp_idx_q  <= cmp_idx_d;
    live_idx_q <= live_idx_d;
    free_idx_q <= free_idx_d;
    rsp_q      <= rsp_d;
  end

  always_comb begin
    expired = ~(req_q.now_ms - rd_i.expiry)  >> 31 == 32'd1;
    foreign = req_q.server_id_present && (req_q.server_id != cfg_i.server_ip);
    dyn     = !req_q.reserved_hit && (live_fnd_q || free_fnd_q);
    dyn_idx = live_fnd_q ? live_idx_q : free_idx_q;
    want    = req_q.requested_present ? req_q.requested_ip : req_q.client_addr;
    ok      = 1'b0;
    offer   = '0;

    state_d    = state_q;
    req_d      = req_q;
    lease_ms_d = lease_ms_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    live_fnd_d = live_fnd_q;
    live_idx_d = live_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_en_o    = 1'b0;
    rd_idx_o   = cnt_q[IDX_W-1:0];
    wr_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d      = req_i;
          lease_ms_d = 32'(cfg_i.lease_secs * MS_PER_SEC);
          cnt_d      = '0;
          live_fnd_d = 1'b0;
          free_fnd_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // One read issued per cycle; the slot read in the previous cycle is compared now.
        if (cnt_q < pool_size_i) begin
          rd_en_o   = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IDX_W-1:0];
        end
        if (cmp_vld_q) begin
          if (rd_i.used && !expired && (rd_i.mac == req_q.client_mac) && !live_fnd_q) begin
            live_fnd_d = 1'b1;
            live_idx_d = cmp_idx_q;
          end
          if ((!rd_i.used || expired) && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
        end
        if (!cmp_vld_q && (cnt_q == pool_size_i)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        rsp_d   = '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
        wr_o.mac    = req_q.client_mac;
        wr_o.idx    = dyn_idx;
        wr_o.expiry = req_q.now_ms + TENTATIVE_MS;
        if (req_q.req_type == REQ_LOOKUP) begin
          if (req_q.reserved_hit) begin
            rsp_d.reply            = RPL_FOUND;
            rsp_d.your_ip          = {cfg_i.server_ip[31:8], req_q.reserved_octet};
            rsp_d.from_reservation = 1'b1;
          end else if (live_fnd_q) begin
            rsp_d.reply      = RPL_FOUND;
            rsp_d.your_ip    = {cfg_i.server_ip[31:8],
                                8'(cfg_i.pool_first + 8'(live_idx_q))};
            rsp_d.lease_slot = 3'(live_idx_q);
          end else begin
            rsp_d.reply = RPL_MISSING;
          end
        end else if (req_q.req_type < REQ_LOOKUP) begin
          if (foreign || (req_q.req_type inside {REQ_RELEASE, REQ_DECLINE})) begin
            // A request to another server also gives up the local lease.
            if (live_fnd_q && (!foreign || (req_q.req_type == REQ_REQUEST))) begin
              wr_o.clr_used = 1'b1;
              wr_o.idx      = live_idx_q;
            end
          end else if (req_q.req_type == REQ_INFORM) begin
            rsp_d.reply   = RPL_ACK;
            rsp_d.your_ip = req_q.client_addr;
          end else if (req_q.req_type inside {REQ_DISCOVER, REQ_REQUEST}) begin
            if (req_q.reserved_hit) begin
              ok                     = 1'b1;
              offer                  = {cfg_i.server_ip[31:8], req_q.reserved_octet};
              rsp_d.from_reservation = 1'b1;
            end else if (dyn) begin
              ok               = 1'b1;
              offer            = {cfg_i.server_ip[31:8],
                                  8'(cfg_i.pool_first + 8'(dyn_idx))};
              rsp_d.lease_slot = 3'(dyn_idx);
              // A fresh slot is held tentatively until a matching request.
              wr_o.wr_en       = !live_fnd_q;
            end else begin
              rsp_d.pool_full = 1'b1;
            end
            if (ok) begin
              if (req_q.req_type == REQ_DISCOVER) begin
                rsp_d.reply   = RPL_OFFER;
                rsp_d.your_ip = offer;
              end else if (want != offer) begin
                rsp_d.reply = RPL_NAK;
              end else begin
                rsp_d.reply   = RPL_ACK;
                rsp_d.your_ip = offer;
                if (dyn) begin
                  wr_o.wr_en  = 1'b1;
                  wr_o.expiry = req_q.now_ms + lease_ms_q;
                end
              end
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/dhcp_lease_table_core.sv @@
// Lease allocation for a small DHCP server. Raise start with a parsed request
// on req_i while busy is low; the block scans its lease memory one slot per
// cycle over the single read port, decides, and writes back at most one slot.
// Exactly one result follows on rsp_o in the first cycle that busy is low
// again, marked by done_o for a single cycle. The receiver cannot stall: the
// result must be captured in that cycle. Configuration writes take effect at
// once and should be made while busy is low; they do not clear the lease table.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_lease_table_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  dhcplt_pkg::req_t                req_i,
  output logic                            done_o,
  output dhcplt_pkg::rsp_t                rsp_o,
  input  wire                             cfg_we_i,
  input  wire [dhcplt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [31:0]                      cfg_wdata_i
);
  import dhcplt_pkg::*;

  cfg_t             cfg;
  logic [CNT_W-1:0] pool_size;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  slot_rd_t         rd;
  slot_wr_t         wr;

  dhcplt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .pool_size_o (pool_size)
  );

  dhcplt_lease_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .wr_i     (wr),
    .rd_o     (rd)
  );

  dhcplt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .pool_size_i (pool_size),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
